// ----- hdl/markov_led_flicker_pwm_unit_macros.svh -----
// ----------------------------------------------------------------------------
// markov_led_flicker_pwm_unit_macros
// assertion macros shared by the led flicker modules
// ----------------------------------------------------------------------------
`ifndef MARKOV_LED_FLICKER_PWM_UNIT_MACROS_SVH
`define MARKOV_LED_FLICKER_PWM_UNIT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MLFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MLFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mlfp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfp_pkg
// types, constants and chain tables of the led flicker pwm block
// ----------------------------------------------------------------------------
`default_nettype none

package mlfp_pkg;

    // channels that can be driven and pwm period
    localparam int NUM_CHANNELS = 8;
    localparam int PWM_LEVELS   = 256;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int CH_W     = 3;
    localparam int DRAW_W   = 7;
    localparam int STATE_W  = 4;
    localparam int LEVEL_W  = 8;
    localparam int COUNT_W  = 4;
    localparam int CH_SLOTS = 2 ** CH_W;

    // draws above this value leave the chain where it is
    localparam logic [DRAW_W-1:0] DRAW_LIMIT = DRAW_W'(100);

    // request opcodes
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK = 2'd0,
        ACT_STEP = 2'd1,
        ACT_STOP = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // one result request
    typedef struct packed {
        logic [CH_SLOTS-1:0] pin_pattern;
        logic [STATE_W-1:0]  channel_state;
        logic [LEVEL_W-1:0]  channel_level;
    } result_t;

    // brightness of each chain state
    function automatic logic [LEVEL_W-1:0] level_of(input logic [STATE_W-1:0] s);
        logic [LEVEL_W-1:0] v;
        case (s)
            4'd0:    v = 8'd0;
            4'd1:    v = 8'd1;
            4'd2:    v = 8'd4;
            4'd3:    v = 8'd8;
            4'd4:    v = 8'd16;
            4'd5:    v = 8'd32;
            4'd6:    v = 8'd64;
            4'd7:    v = 8'd128;
            4'd8:    v = 8'd255;
            4'd9:    v = 8'd128;
            4'd10:   v = 8'd64;
            4'd11:   v = 8'd32;
            4'd12:   v = 8'd16;
            4'd13:   v = 8'd8;
            4'd14:   v = 8'd4;
            4'd15:   v = 8'd1;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // threshold for the first successor: the on state is a coin flip
    function automatic logic [DRAW_W-1:0] first_prob(input logic [STATE_W-1:0] s);
        logic [DRAW_W-1:0] v;
        if (s == 4'd8) begin
            v = 7'd50;
        end else begin
            v = 7'd90;
        end
        return v;
    endfunction

    // first successor
    function automatic logic [STATE_W-1:0] first_next(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] v;
        case (s)
            4'd0:    v = 4'd0;
            4'd8:    v = 4'd8;
            4'd15:   v = 4'd0;
            default: v = s + 4'd1;
        endcase
        return v;
    endfunction

    // second successor
    function automatic logic [STATE_W-1:0] second_next(input logic [STATE_W-1:0] s);
        logic [STATE_W-1:0] v;
        case (s)
            4'd0:    v = 4'd1;
            4'd8:    v = 4'd9;
            default: v = 4'd0 - s;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mlfp_out_buf.sv -----
// ----------------------------------------------------------------------------
// mlfp_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
`default_nettype none

`include "markov_led_flicker_pwm_unit_macros.svh"

module mlfp_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire mlfp_pkg::result_t push_data,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mlfp_pkg::result_t     out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    mlfp_pkg::result_t out_data_reg, out_data_next;
    mlfp_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    // room for one more request as long as the skid slot is free
    assign room      = !skid_valid_reg;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // slot control
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && !pop) begin
            if (push) begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end else if (skid_valid_reg) begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end else begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // skid slot only fills behind a full output slot
    `MLFP_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg, "skid without head")
    // a full buffer never takes a request
    `MLFP_ASSERT_ALWAYS(a_no_push_full, !(push && skid_valid_reg), "push into full buffer")
    // a waiting head moves the skid entry forward once taken
    `MLFP_ASSERT_NEXT(a_skid_advance, pop && skid_valid_reg,
        out_valid_reg && out_data_reg == $past(skid_data_reg), "skid entry lost")

endmodule

`default_nettype wire

// ----- hdl/markov_led_flicker_pwm_unit.sv -----
// ----------------------------------------------------------------------------
// markov_led_flicker_pwm_unit
// led flicker generator: per-channel markov chains driving pwm pins
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while s_ready is high and returns one
// result per request through the registered result buffer. Every request is
// handled in combinational logic between the held channel state and a
// two-entry result buffer; that buffer lets one more request in while a
// result waits, after which s_ready drops until m_ready frees a slot. A tick
// compares all driven brightnesses against the pwm counter in parallel, a
// step looks up the chain tables for one channel, a stop clears brightness
// and pins. All state is in flip-flops and is ready right out of reset.
`default_nettype none

`include "markov_led_flicker_pwm_unit_macros.svh"

module markov_led_flicker_pwm_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [mlfp_pkg::COUNT_W-1:0]  cfg_wr_data,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [mlfp_pkg::ACTION_W-1:0] s_action,
    input  wire logic [mlfp_pkg::CH_W-1:0]     s_channel_index,
    input  wire logic [mlfp_pkg::DRAW_W-1:0]   s_random_value,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mlfp_pkg::CH_SLOTS-1:0]      m_pin_pattern,
    output logic [mlfp_pkg::STATE_W-1:0]       m_channel_state,
    output logic [mlfp_pkg::LEVEL_W-1:0]       m_channel_level
);

    localparam logic [mlfp_pkg::LEVEL_W-1:0] PWM_MAX =
        mlfp_pkg::LEVEL_W'(mlfp_pkg::PWM_LEVELS - 1);
    localparam logic [mlfp_pkg::COUNT_W-1:0] CH_MAX =
        mlfp_pkg::COUNT_W'(mlfp_pkg::NUM_CHANNELS);

    logic [mlfp_pkg::COUNT_W-1:0]                           active_reg;
    logic [mlfp_pkg::CH_SLOTS-1:0][mlfp_pkg::STATE_W-1:0]   chain_reg, chain_next;
    logic [mlfp_pkg::CH_SLOTS-1:0][mlfp_pkg::LEVEL_W-1:0]   bright_reg, bright_next;
    logic [mlfp_pkg::LEVEL_W-1:0]                           pwm_reg, pwm_next;
    logic [mlfp_pkg::CH_SLOTS-1:0]                          pin_reg, pin_next;

    logic                         accept;
    logic [mlfp_pkg::COUNT_W-1:0] driven;
    logic [mlfp_pkg::CH_SLOTS-1:0] drive_mask;
    logic [mlfp_pkg::CH_SLOTS-1:0] tick_pins;
    logic                         step_ok;
    logic [mlfp_pkg::STATE_W-1:0] held_state, new_state;
    logic [mlfp_pkg::LEVEL_W-1:0] new_level;
    mlfp_pkg::action_t            action;
    mlfp_pkg::result_t            result;
    mlfp_pkg::result_t            out_data;

    assign accept = s_valid && s_ready;
    assign action = mlfp_pkg::action_t'(s_action);

    // driven channel count and mask
    assign driven = (active_reg > CH_MAX) ? CH_MAX : active_reg;
    always_comb begin
        for (int i = 0; i < mlfp_pkg::CH_SLOTS; i++) begin
            drive_mask[i] = mlfp_pkg::COUNT_W'(i) < driven;
        end
    end

    // pwm compare for all channels
    always_comb begin
        for (int i = 0; i < mlfp_pkg::CH_SLOTS; i++) begin
            tick_pins[i] = drive_mask[i] && (bright_reg[i] > pwm_reg);
        end
    end

    // chain step for the addressed channel
    assign step_ok    = {1'b0, s_channel_index} < driven;
    assign held_state = chain_reg[s_channel_index];
    always_comb begin
        if (s_random_value <= mlfp_pkg::first_prob(held_state)) begin
            new_state = mlfp_pkg::first_next(held_state);
        end else if (s_random_value <= mlfp_pkg::DRAW_LIMIT) begin
            new_state = mlfp_pkg::second_next(held_state);
        end else begin
            new_state = held_state;
        end
    end
    assign new_level = mlfp_pkg::level_of(new_state);

    // next state and result
    always_comb begin
        chain_next  = chain_reg;
        bright_next = bright_reg;
        pwm_next    = pwm_reg;
        pin_next    = pin_reg;
        result.channel_state = '0;
        result.channel_level = '0;
        case (action)
            mlfp_pkg::ACT_TICK: begin
                pin_next = tick_pins;
                pwm_next = (pwm_reg >= PWM_MAX) ? '0 : pwm_reg + 1'b1;
            end
            mlfp_pkg::ACT_STEP: begin
                if (step_ok) begin
                    chain_next[s_channel_index]  = new_state;
                    bright_next[s_channel_index] = new_level;
                    result.channel_state = new_state;
                    result.channel_level = new_level;
                end
            end
            mlfp_pkg::ACT_STOP: begin
                bright_next = '0;
                pin_next    = '0;
            end
            mlfp_pkg::ACT_NONE: begin
                pin_next = pin_reg;
            end
            default: begin
                pin_next = pin_reg;
            end
        endcase
        result.pin_pattern = pin_next;
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= mlfp_pkg::COUNT_W'(8);
        end else if (cfg_wr_en) begin
            active_reg <= cfg_wr_data;
        end
    end

    // channel state, updated on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg  <= '0;
            bright_reg <= '0;
            pwm_reg    <= '0;
            pin_reg    <= '0;
        end else if (accept) begin
            chain_reg  <= chain_next;
            bright_reg <= bright_next;
            pwm_reg    <= pwm_next;
            pin_reg    <= pin_next;
        end
    end

    // result buffer
    mlfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_pin_pattern   = out_data.pin_pattern;
    assign m_channel_state = out_data.channel_state;
    assign m_channel_level = out_data.channel_level;

    // stop leaves every brightness and pin cleared
    `MLFP_ASSERT_NEXT(a_stop_clears, accept && action == mlfp_pkg::ACT_STOP,
        bright_reg == '0 && pin_reg == '0, "stop did not clear")
    // pins never light above the driven count
    `MLFP_ASSERT_ALWAYS(a_pins_driven, (tick_pins & ~drive_mask) == '0, "undriven pin lit")
    // chain positions only move on an accepted step
    `MLFP_ASSERT_NEXT(a_chain_hold, !(accept && action == mlfp_pkg::ACT_STEP),
        chain_reg == $past(chain_reg), "chain moved without step")

endmodule

`default_nettype wire
